FILE: src/quadrature_position_speed_defines.svh
// Assertion macros shared by the quadrature position and speed block.
`ifndef QUADRATURE_POSITION_SPEED_DEFINES_SVH
`define QUADRATURE_POSITION_SPEED_DEFINES_SVH
`ifndef SYNTHESIS
`define QPS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define QPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define QPS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define QPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: src/qps_pkg.sv
// Types and constants of the quadrature position and speed block.
`default_nettype none
package qps_pkg;

  localparam int POS_W      = 32;
  localparam int SPEED_W    = 21;
  localparam int TIMEOUT_W  = 24;
  localparam int SCALE_W    = 20;
  localparam int STEP_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [SCALE_W-1:0] SPEED_SCALE = 20'd1000000;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_RISE = 2'd1;
  localparam logic [1:0] OP_FALL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_EN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_MIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_MAX  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd3;

  localparam logic signed [POS_W-1:0] POS_MIN_RESET = 32'sh8000_0000;
  localparam logic signed [POS_W-1:0] POS_MAX_RESET = 32'sh7FFF_FFFF;
  localparam logic [TIMEOUT_W-1:0]    TIMEOUT_RESET = 24'd100000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

FILE: src/qps_in_if.sv
// Input channel: encoder events.
`default_nettype none
interface qps_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic       b_level;

  modport source (output valid, output op, output b_level, input ready);
  modport sink (input valid, input op, input b_level, output ready);
endinterface
`default_nettype wire

FILE: src/qps_out_if.sv
// Output channel: position and speed results.
`default_nettype none
interface qps_out_if;
  import qps_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [POS_W-1:0]   position;
  logic signed [SPEED_W-1:0] speed;

  modport source (output valid, output position, output speed, input ready);
  modport sink (input valid, input position, input speed, output ready);
endinterface
`default_nettype wire

FILE: src/qps_cfg_if.sv
// Configuration write channel.
`default_nettype none
interface qps_cfg_if;
  import qps_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: src/quadrature_position_speed.sv
// Quadrature decoder at twice resolution with edge-period speed output.
// Result: a tick, an unused op, a disabled edge, a stale edge or a zero-period edge presents its
// result in the cycle after acceptance; other edges first wait for the 20-step divider.
// Flow: no new item is accepted until the previous result has been taken by the receiver.
// Reset: synchronous; clears position, speed, period count and timeout flags, loads register
// defaults.
`default_nettype none
`include "quadrature_position_speed_defines.svh"
module quadrature_position_speed #(
  parameter int PERIOD_WIDTH = 24
) (
  input wire logic clk,
  input wire logic rst,
  qps_in_if.sink   enc,
  qps_out_if.source res,
  qps_cfg_if.sink  cfg
);
  import qps_pkg::*;

  localparam int CMP_W = (PERIOD_WIDTH > TIMEOUT_W) ? PERIOD_WIDTH : TIMEOUT_W;

  state_t state;
  state_t state_next;

  logic                      cfg_speed_en;
  logic signed [POS_W-1:0]   cfg_pos_min;
  logic signed [POS_W-1:0]   cfg_pos_max;
  logic [TIMEOUT_W-1:0]      cfg_timeout;

  logic signed [POS_W-1:0]   position_count;
  logic signed [SPEED_W-1:0] speed_value;
  logic [PERIOD_WIDTH-1:0]   period_ticks;
  logic [PERIOD_WIDTH-1:0]   ticks_inc;
  logic                      timeout_armed;
  logic                      speed_stale;
  logic                      dir_up;

  logic                      accept;
  logic                      is_tick;
  logic                      is_edge;
  logic                      up;
  logic                      need_div;
  logic                      div_start;
  logic signed [SPEED_W-1:0] mag_now;
  logic [SCALE_W-1:0]        quotient;
  div_stat_t                 div_stat;

  qps_div #(
    .WIDTH (PERIOD_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (period_ticks),
    .stat     (div_stat),
    .quotient (quotient)
  );

  assign accept   = enc.valid && enc.ready;
  assign is_tick  = (enc.op == OP_TICK);
  assign is_edge  = (enc.op == OP_RISE) || (enc.op == OP_FALL);
  assign up       = (enc.op == OP_RISE) ? !enc.b_level : enc.b_level;
  assign need_div = is_edge && cfg_speed_en && !speed_stale && (period_ticks != '0);
  assign ticks_inc = (period_ticks == '1) ? period_ticks : period_ticks + PERIOD_WIDTH'(1);
  assign mag_now  = speed_stale ? '0 : SPEED_W'(SPEED_SCALE);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = need_div ? ST_DIV : ST_OUT;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (res.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    enc.ready = 1'b0;
    res.valid = 1'b0;
    div_start = 1'b0;
    unique case (state)
      ST_IDLE: begin
        enc.ready = 1'b1;
        div_start = enc.valid && need_div;
      end
      ST_DIV: begin
      end
      ST_OUT: begin
        res.valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_speed_en <= 1'b1;
      cfg_pos_min  <= POS_MIN_RESET;
      cfg_pos_max  <= POS_MAX_RESET;
      cfg_timeout  <= TIMEOUT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_SPEED_EN: cfg_speed_en <= cfg.data[0];
        CFG_POS_MIN:  cfg_pos_min  <= cfg.data;
        CFG_POS_MAX:  cfg_pos_max  <= cfg.data;
        CFG_TIMEOUT:  cfg_timeout  <= cfg.data[TIMEOUT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_count <= '0;
      speed_value    <= '0;
      period_ticks   <= '0;
      timeout_armed  <= 1'b0;
      speed_stale    <= 1'b0;
      dir_up         <= 1'b0;
    end else if (accept && is_tick) begin
      if (cfg_speed_en) begin
        period_ticks <= ticks_inc;
        if (timeout_armed && (CMP_W'(ticks_inc) >= CMP_W'(cfg_timeout))) begin
          speed_value   <= '0;
          speed_stale   <= 1'b1;
          timeout_armed <= 1'b0;
        end
      end
    end else if (accept && is_edge) begin
      dir_up <= up;
      if (up) begin
        if (position_count < cfg_pos_max) begin
          position_count <= position_count + POS_W'(1);
        end
      end else begin
        if (position_count > cfg_pos_min) begin
          position_count <= position_count - POS_W'(1);
        end
      end
      if (cfg_speed_en) begin
        period_ticks  <= '0;
        timeout_armed <= 1'b1;
        speed_stale   <= 1'b0;
        // Stale or zero period: settle now; otherwise wait for the divider.
        if (!need_div) begin
          speed_value <= up ? mag_now : -mag_now;
        end
      end else begin
        speed_value <= '0;
      end
    end else if ((state == ST_DIV) && div_stat.done) begin
      speed_value <= dir_up ? SPEED_W'(quotient) : -SPEED_W'(quotient);
    end
  end

  assign res.position = position_count;
  assign res.speed    = cfg_speed_en ? speed_value : '0;

  `QPS_ASSERT_IMPLY(a_ready_excl_valid, clk, rst, enc.ready, !res.valid, "ready while result held")
  `QPS_ASSERT_IMPLY(a_done_in_div, clk, rst, div_stat.done, state == ST_DIV, "divider done outside DIV")
  `QPS_ASSERT_NEXT(a_div_launch, clk, rst, accept && need_div, div_stat.busy && (state == ST_DIV), "divide not launched")
  `QPS_ASSERT_IMPLY(a_disabled_zero, clk, rst, res.valid && !cfg_speed_en, res.speed == '0, "speed nonzero while disabled")

endmodule
`default_nettype wire

FILE: src/qps_div.sv
// Restoring divider: constant speed scale over the edge period, one bit a cycle.
`default_nettype none
module qps_div #(
  parameter int WIDTH = 24
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [WIDTH-1:0]            divisor,
  output qps_pkg::div_stat_t               stat,
  output logic [qps_pkg::SCALE_W-1:0]      quotient
);
  import qps_pkg::*;

  logic [WIDTH-1:0]   dvsr;
  logic [WIDTH:0]     rem;
  logic [WIDTH:0]     rem_next;
  logic [WIDTH:0]     shifted;
  logic [SCALE_W-1:0] quo;
  logic [STEP_W-1:0]  cnt;
  logic               busy;
  logic               done;
  logic               ge;

  // Quotient register doubles as the dividend shifter.
  always_comb begin
    shifted  = {rem[WIDTH-1:0], quo[SCALE_W-1]};
    ge       = (shifted >= {1'b0, dvsr});
    rem_next = ge ? (shifted - {1'b0, dvsr}) : shifted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvsr <= divisor;
      rem  <= '0;
      quo  <= SPEED_SCALE;
      cnt  <= STEP_W'(SCALE_W - 1);
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[SCALE_W-2:0], ge};
      cnt <= cnt - STEP_W'(1);
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule
`default_nettype wire

FILE: bench/quadrature_position_speed_tb.sv
// Self-checking bench for the quadrature position and speed decoder.
`timescale 1ns / 1ps
module quadrature_position_speed_tb;
  import qps_pkg::*;

  localparam int PERIOD_W       = 24;
  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 8;
  localparam int CYCLE_LIMIT    = 2_000_000;
  localparam int DRAIN_CYCLES   = 30;
  localparam int PHASE_ITEMS    = 220;
  localparam int NUM_PHASES     = 8;
  localparam int MAX_REPORTS    = 10;
  localparam int DIRECTED_ROWS  = 36;

  typedef struct packed {
    logic signed [POS_W-1:0]   position;
    logic signed [SPEED_W-1:0] speed;
  } reading_t;

  typedef enum logic {ROW_EVENT, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [1:0]            op;
    logic                  b_level;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    logic                  known;
    reading_t              want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  qps_in_if  enc_if ();
  qps_out_if res_if ();
  qps_cfg_if cfg_if ();

  quadrature_position_speed #(.PERIOD_WIDTH(PERIOD_W)) dut (
    .clk (clk),
    .rst (rst),
    .enc (enc_if),
    .res (res_if),
    .cfg (cfg_if)
  );

  always #HALF_PERIOD clk = ~clk;

  // Decoder image: registers, then running state.
  logic                    speed_on         = 1'b1;
  logic signed [POS_W-1:0] pos_floor        = POS_MIN_RESET;
  logic signed [POS_W-1:0] pos_ceiling      = POS_MAX_RESET;
  logic [TIMEOUT_W-1:0]    timeout_ticks    = TIMEOUT_RESET;
  logic signed [POS_W-1:0] position_est     = '0;
  logic [SPEED_W-1:0]      edge_speed       = '0;
  logic [PERIOD_W-1:0]     ticks_since_edge = '0;
  logic                    watch_armed      = 1'b0;
  logic                    speed_expired    = 1'b0;

  reading_t  expected_readings[$];
  stim_row_t directed_rows[DIRECTED_ROWS];

  int events_sent      = 0;
  int edges_sent       = 0;
  int timeouts_hit     = 0;
  int readings_checked = 0;
  int reg_writes       = 0;
  int mismatches       = 0;
  int cycle_count      = 0;
  int idle_pct         = 0;
  int stall_pct        = 0;

  function automatic reading_t decode_event(logic [1:0] op, logic b_level);
    logic                up;
    logic [PERIOD_W-1:0] elapsed;
    logic [31:0]         quotient;
    reading_t            r;
    if (op == OP_TICK) begin
      if (speed_on) begin
        if (ticks_since_edge != '1) ticks_since_edge = ticks_since_edge + 1'b1;
        if (watch_armed && ticks_since_edge >= timeout_ticks) begin
          edge_speed    = '0;
          speed_expired = 1'b1;
          watch_armed   = 1'b0;
          timeouts_hit++;
        end
      end
    end else if (op == OP_RISE || op == OP_FALL) begin
      up       = (op == OP_RISE) ? !b_level : b_level;
      quotient = '0;
      edges_sent++;
      if (speed_on) begin
        elapsed          = ticks_since_edge;
        ticks_since_edge = '0;
        watch_armed      = 1'b1;
        // first edge after a timeout reports standstill
        if (speed_expired) quotient = '0;
        else if (elapsed == '0) quotient = SPEED_SCALE;
        else quotient = SPEED_SCALE / elapsed;
        speed_expired = 1'b0;
      end
      // hold a count that sits outside the bounds until a step moves it inward
      if (up) begin
        if (position_est < pos_ceiling) position_est = position_est + 1;
        edge_speed = quotient[SPEED_W-1:0];
      end else begin
        if (position_est > pos_floor) position_est = position_est - 1;
        edge_speed = -quotient[SPEED_W-1:0];
      end
    end
    r.position = position_est;
    r.speed    = speed_on ? edge_speed : '0;
    return r;
  endfunction

  function automatic stim_row_t evt(logic [1:0] op, logic b_level);
    stim_row_t row;
    row         = '0;
    row.kind    = ROW_EVENT;
    row.op      = op;
    row.b_level = b_level;
    return row;
  endfunction

  function automatic stim_row_t evt_known(logic [1:0] op, logic b_level,
                                          logic signed [POS_W-1:0] position,
                                          logic signed [SPEED_W-1:0] speed);
    stim_row_t row;
    row               = evt(op, b_level);
    row.known         = 1'b1;
    row.want.position = position;
    row.want.speed    = speed;
    return row;
  endfunction

  function automatic stim_row_t reg_wr(logic [CFG_IDX_W-1:0] index,
                                       logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row       = '0;
    row.kind  = ROW_WRITE;
    row.index = index;
    row.data  = data;
    return row;
  endfunction

  task automatic wait_drained();
    enc_if.valid <= 1'b0;
    while (expected_readings.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    wait_drained();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    case (index)
      CFG_SPEED_EN: speed_on      = data[0];
      CFG_POS_MIN:  pos_floor     = data;
      CFG_POS_MAX:  pos_ceiling   = data;
      CFG_TIMEOUT:  timeout_ticks = data[TIMEOUT_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_event(logic [1:0] op, logic b_level, logic known, reading_t want);
    reading_t predicted;
    enc_if.valid   <= 1'b1;
    enc_if.op      <= op;
    enc_if.b_level <= b_level;
    do @(posedge clk); while (!enc_if.ready);
    predicted = decode_event(op, b_level);
    expected_readings.push_back(known ? want : predicted);
    events_sent++;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      enc_if.valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  always @(negedge clk) res_if.ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    reading_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (expected_readings.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: reading with nothing expected: position %0d speed %0d",
                   $time, res_if.position, res_if.speed);
        mismatches++;
      end else begin
        want = expected_readings.pop_front();
        readings_checked++;
        if (res_if.position !== want.position || res_if.speed !== want.speed) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: reading %0d: position exp %0d got %0d, speed exp %0d got %0d",
                     $time, readings_checked, $signed(want.position), res_if.position,
                     $signed(want.speed), res_if.speed);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles, %0d readings outstanding",
               cycle_count, expected_readings.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int         ph;
    int         sent;
    int         burst;
    int         pick;
    int         long_max;
    logic       turning_up;
    logic       a_high;
    logic [1:0] op;
    logic       b_level;

    rst            = 1'b1;
    enc_if.valid   = 1'b0;
    enc_if.op      = OP_TICK;
    enc_if.b_level = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = CFG_SPEED_EN;
    cfg_if.data    = '0;
    res_if.ready   = 1'b0;

    directed_rows = '{
      evt_known(OP_TICK + 2'd3, 1'b0, 32'sd0, 21'sd0),
      evt(OP_TICK, 1'b0),
      evt_known(OP_RISE, 1'b0, 32'sd1, 21'sd1000000),
      // zero period right after the previous edge
      evt_known(OP_RISE, 1'b1, 32'sd0, -21'sd1000000),
      evt(OP_FALL, 1'b1),
      evt(OP_FALL, 1'b0),
      evt(OP_TICK, 1'b1),
      evt(OP_TICK, 1'b0),
      evt(OP_FALL, 1'b1),
      reg_wr(CFG_TIMEOUT, 32'd2),
      evt(OP_TICK, 1'b0),
      evt_known(OP_TICK, 1'b1, 32'sd1, 21'sd0),
      evt_known(OP_RISE, 1'b0, 32'sd2, 21'sd0),
      evt(OP_TICK, 1'b0),
      evt(OP_RISE, 1'b1),
      reg_wr(CFG_SPEED_EN, 32'd0),
      evt_known(OP_TICK, 1'b0, 32'sd1, 21'sd0),
      evt_known(OP_RISE, 1'b0, 32'sd2, 21'sd0),
      evt_known(OP_TICK + 2'd3, 1'b1, 32'sd2, 21'sd0),
      reg_wr(CFG_SPEED_EN, 32'd1),
      reg_wr(CFG_POS_MAX, 32'd2),
      reg_wr(CFG_POS_MIN, 32'd1),
      evt(OP_RISE, 1'b0),
      evt(OP_FALL, 1'b0),
      evt(OP_FALL, 1'b0),
      // inverted bounds
      reg_wr(CFG_POS_MIN, 32'd3),
      reg_wr(CFG_POS_MAX, -32'sd3),
      evt(OP_RISE, 1'b0),
      evt(OP_RISE, 1'b1),
      reg_wr(CFG_POS_MIN, POS_MIN_RESET),
      reg_wr(CFG_POS_MAX, POS_MAX_RESET),
      reg_wr(CFG_TIMEOUT, 32'd0),
      evt(OP_TICK, 1'b0),
      evt(OP_FALL, 1'b1),
      reg_wr(CFG_TIMEOUT, 32'hFF_FFFF),
      evt(OP_TICK + 2'd3, 1'b0)
    };

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (directed_rows[i].kind == ROW_WRITE)
        write_register(directed_rows[i].index, directed_rows[i].data);
      else
        send_event(directed_rows[i].op, directed_rows[i].b_level,
                   directed_rows[i].known, directed_rows[i].want);
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          write_register(CFG_POS_MIN, POS_MIN_RESET);
          write_register(CFG_POS_MAX, POS_MAX_RESET);
          write_register(CFG_TIMEOUT, 32'hFF_FFFF);
        end
        1: begin
          write_register(CFG_TIMEOUT, 32'd1);
          write_register(CFG_POS_MIN, position_est - 5);
          write_register(CFG_POS_MAX, position_est + 5);
        end
        2: begin
          write_register(CFG_TIMEOUT, $urandom_range(40, 2));
          write_register(CFG_POS_MIN, position_est - $urandom_range(3));
          write_register(CFG_POS_MAX, position_est + $urandom_range(3));
        end
        3: begin
          write_register(CFG_SPEED_EN, $urandom() & 32'hFFFF_FFFE);
          write_register(CFG_POS_MIN, POS_MIN_RESET);
          write_register(CFG_POS_MAX, POS_MAX_RESET);
        end
        4: begin
          write_register(CFG_SPEED_EN, $urandom() | 32'd1);
          write_register(CFG_POS_MIN, position_est + $urandom_range(4, 1));
          write_register(CFG_POS_MAX, position_est - $urandom_range(4, 1));
          write_register(CFG_TIMEOUT, $urandom_range(150, 3));
        end
        5: begin
          write_register(CFG_POS_MIN, position_est);
          write_register(CFG_POS_MAX, position_est);
          write_register(CFG_TIMEOUT, 32'd20);
        end
        6: begin
          write_register(CFG_POS_MIN, $urandom());
          write_register(CFG_POS_MAX, $urandom());
          write_register(CFG_TIMEOUT, $urandom());
        end
        default: begin
          write_register(CFG_POS_MIN, POS_MIN_RESET);
          write_register(CFG_POS_MAX, POS_MAX_RESET);
          write_register(CFG_TIMEOUT, 32'd8);
        end
      endcase
      case (ph % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 85; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 85; end
        default: begin idle_pct = 6;  stall_pct = 6;  end
      endcase

      // Model a turning shaft: tick bursts between alternating A edges,
      // with an occasional reversal and some out-of-order noise.
      sent       = 0;
      turning_up = $urandom_range(1);
      a_high     = $urandom_range(1);
      while (sent < PHASE_ITEMS) begin
        pick     = $urandom_range(99);
        long_max = int'(timeout_ticks) + 2;
        if (long_max > 100) long_max = 100;
        if (long_max < 16) long_max = 16;
        if (pick < 65) burst = $urandom_range(2);
        else if (pick < 92) burst = $urandom_range(15, 3);
        else burst = $urandom_range(long_max, 16);
        repeat (burst) begin
          send_event(OP_TICK, $urandom_range(1), 1'b0, '0);
          sent++;
        end
        if ($urandom_range(9) == 0) begin
          op      = $urandom_range(3);
          b_level = $urandom_range(1);
        end else begin
          if ($urandom_range(19) == 0) turning_up = !turning_up;
          op      = a_high ? OP_FALL : OP_RISE;
          b_level = (op == OP_RISE) ? !turning_up : turning_up;
          a_high  = !a_high;
        end
        send_event(op, b_level, 1'b0, '0);
        sent++;
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Drove %0d encoder items (%0d A edges, %0d speed timeouts), %0d register writes",
             events_sent, edges_sent, timeouts_hit, reg_writes);
    $display("Checked %0d readings across %0d bound/timeout/pacing phases, %0d mismatches",
             readings_checked, NUM_PHASES, mismatches);
    if (mismatches == 0 && expected_readings.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
